// ===== rtl/core/flash_write_command_splitter_unit_assert.svh =====
// assertion macros shared by the splitter rtl
`ifndef FLASH_WRITE_COMMAND_SPLITTER_UNIT_ASSERT_SVH
`define FLASH_WRITE_COMMAND_SPLITTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked only while out of reset
`define FWCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fwcs assertion failed");
// property checked on every edge, reset included
`define FWCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fwcs assertion failed");
`else
`define FWCS_ASSERT(lbl, clk, rstn, prop)
`define FWCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/fwcs_pkg.sv =====
// types, constants and the control program of the write command splitter
`timescale 1ns / 1ps
`default_nettype none

package fwcs_pkg;

    localparam int ADDR_W            = 24;
    localparam int COUNT_W           = 13;
    localparam int BYTES_W           = 9;
    localparam int OFFSET_W          = 12;

    localparam int SECTOR_LOG2       = 12;
    localparam int PAGE_LOG2         = 8;
    localparam int SECTOR_BYTES      = 1 << SECTOR_LOG2;
    localparam int PAGE_BYTES        = 1 << PAGE_LOG2;
    localparam int MAX_REQUEST_BYTES = 4096;

    // sector offset plus count minus one
    localparam int SUM_W             = 14;
    localparam int SECT_W            = SUM_W - SECTOR_LOG2;
    localparam int PAGE_W            = PAGE_LOG2 + 1;

    localparam logic KIND_ERASE   = 1'b0;
    localparam logic KIND_PROGRAM = 1'b1;

    typedef logic [1:0] t_step;
    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_ERASE = 2'd1;
    localparam t_step STEP_PROG  = 2'd2;
    localparam t_step STEP_SPARE = 2'd3;

    typedef logic [1:0] t_cond;
    localparam t_cond COND_ALWAYS = 2'd0;
    localparam t_cond COND_LOAD   = 2'd1;
    localparam t_cond COND_SECT   = 2'd2;
    localparam t_cond COND_PROG   = 2'd3;

    typedef struct packed {
        logic  take_in;
        logic  emit;
        logic  kind;
        t_cond cond;
        t_step jump_to;
    } t_ucode;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic emit_erase;
        logic emit_prog;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic len_zero;
        logic sect_last;
        logic prog_last;
        logic out_free;
    } t_stat;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        begin
            w = '0;
            unique case (step)
                STEP_IDLE: begin
                    w.take_in = 1'b1;
                    w.cond    = COND_LOAD;
                    w.jump_to = STEP_ERASE;
                end
                STEP_ERASE: begin
                    w.emit    = 1'b1;
                    w.kind    = KIND_ERASE;
                    w.cond    = COND_SECT;
                    w.jump_to = STEP_PROG;
                end
                STEP_PROG: begin
                    w.emit    = 1'b1;
                    w.kind    = KIND_PROGRAM;
                    w.cond    = COND_PROG;
                    w.jump_to = STEP_IDLE;
                end
                default: begin
                    w.cond    = COND_ALWAYS;
                    w.jump_to = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/flash_write_command_splitter_unit.sv =====
// top level of the flash write command splitter
//
//   channel   direction   handshake                  fields
//   request   in          i_in_valid / o_in_stall    start_address, byte_count
//   command   out         o_out_valid / i_out_stall  command_kind, target_address,
//                                                    program_bytes, source_offset,
//                                                    last_command
//
// a request is loaded in the idle step, then one command per cycle unless stalled:
// erases first, then page programs.
// the control store steps idle, erase and program; a zero count is taken and dropped.
// a stalled command holds in the output register and the sequencer waits on it.
// reset is synchronous, active low, and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module flash_write_command_splitter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [fwcs_pkg::ADDR_W-1:0]       i_start_address,
    input  wire logic [fwcs_pkg::COUNT_W-1:0]      i_byte_count,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_command_kind,
    output logic [fwcs_pkg::ADDR_W-1:0]            o_target_address,
    output logic [fwcs_pkg::BYTES_W-1:0]           o_program_bytes,
    output logic [fwcs_pkg::OFFSET_W-1:0]          o_source_offset,
    output logic                                   o_last_command
);

    fwcs_pkg::t_ctl  w_ctl;
    fwcs_pkg::t_stat w_stat;

    fwcs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    fwcs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start_address  (i_start_address),
        .i_byte_count     (i_byte_count),
        .i_ctl            (w_ctl),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_command_kind   (o_command_kind),
        .o_target_address (o_target_address),
        .o_program_bytes  (o_program_bytes),
        .o_source_offset  (o_source_offset),
        .o_last_command   (o_last_command)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fwcs_seq.sv =====
// step counter and control store of the command splitter
`timescale 1ns / 1ps
`default_nettype none
`include "flash_write_command_splitter_unit_assert.svh"

module fwcs_seq (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output logic               o_in_stall,
    input  wire fwcs_pkg::t_stat     i_stat,
    output fwcs_pkg::t_ctl     o_ctl
);

    fwcs_pkg::t_step  r_step;
    fwcs_pkg::t_step  n_step;
    fwcs_pkg::t_ucode w_word;
    logic             w_go;
    logic             w_jump;

    assign w_word     = fwcs_pkg::ucode_rom(r_step);
    assign o_in_stall = !w_word.take_in;

    // a command leaves only when the output slot is free
    assign w_go = w_word.emit && i_stat.out_free;

    always_comb begin
        case (w_word.cond)
            fwcs_pkg::COND_ALWAYS: w_jump = 1'b1;
            fwcs_pkg::COND_LOAD:   w_jump = i_in_valid && !i_stat.len_zero;
            fwcs_pkg::COND_SECT:   w_jump = w_go && i_stat.sect_last;
            fwcs_pkg::COND_PROG:   w_jump = w_go && i_stat.prog_last;
            default:               w_jump = 1'b0;
        endcase
    end

    always_comb begin
        o_ctl.load       = w_word.take_in && i_in_valid && !i_stat.len_zero;
        o_ctl.emit_erase = w_go && (w_word.kind == fwcs_pkg::KIND_ERASE);
        o_ctl.emit_prog  = w_go && (w_word.kind == fwcs_pkg::KIND_PROGRAM);
        n_step           = w_jump ? w_word.jump_to : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fwcs_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    `FWCS_ASSERT(a_load_then_busy, i_clk, i_rst_n, o_ctl.load |=> o_in_stall)
    `FWCS_ASSERT(a_no_erase_after_prog, i_clk, i_rst_n,
                 o_ctl.emit_prog |=> !o_ctl.emit_erase)
    `FWCS_ASSERT(a_emit_needs_slot, i_clk, i_rst_n,
                 (o_ctl.emit_erase || o_ctl.emit_prog) |-> i_stat.out_free)

endmodule

`default_nettype wire

// ===== rtl/core/fwcs_dp.sv =====
// address, count and output registers of the command splitter
`timescale 1ns / 1ps
`default_nettype none
`include "flash_write_command_splitter_unit_assert.svh"

module fwcs_dp (
    input  wire  logic                            i_clk,
    input  wire  logic                            i_rst_n,
    input  wire  logic [fwcs_pkg::ADDR_W-1:0]     i_start_address,
    input  wire  logic [fwcs_pkg::COUNT_W-1:0]    i_byte_count,
    input  wire  fwcs_pkg::t_ctl                  i_ctl,
    output fwcs_pkg::t_stat                       o_stat,
    output logic                                  o_out_valid,
    input  wire  logic                            i_out_stall,
    output logic                                  o_command_kind,
    output logic [fwcs_pkg::ADDR_W-1:0]           o_target_address,
    output logic [fwcs_pkg::BYTES_W-1:0]          o_program_bytes,
    output logic [fwcs_pkg::OFFSET_W-1:0]         o_source_offset,
    output logic                                  o_last_command
);

    localparam int AW = fwcs_pkg::ADDR_W;
    localparam int CW = fwcs_pkg::COUNT_W;
    localparam int PW = fwcs_pkg::PAGE_W;
    localparam int SW = fwcs_pkg::SUM_W;
    localparam int NW = fwcs_pkg::SECT_W;
    localparam int SL = fwcs_pkg::SECTOR_LOG2;
    localparam int PL = fwcs_pkg::PAGE_LOG2;

    logic [AW-1:0]                  r_base;
    logic [AW-1:0]                  r_cur;
    logic [CW-1:0]                  r_rem;
    logic [CW-1:0]                  r_off;
    logic [NW-1:0]                  r_sect_left;

    logic                           r_o_valid;
    logic                           r_kind;
    logic [AW-1:0]                  r_taddr;
    logic [fwcs_pkg::BYTES_W-1:0]   r_pbytes;
    logic [fwcs_pkg::OFFSET_W-1:0]  r_soff;
    logic                           r_last;

    logic [CW-1:0]                  w_len;
    logic [SW-1:0]                  w_sum;
    logic [PW-1:0]                  w_room;
    logic [PW-1:0]                  w_size;
    logic                           w_fits;

    // oversized counts are clamped
    assign w_len = (i_byte_count > CW'(fwcs_pkg::MAX_REQUEST_BYTES))
                 ? CW'(fwcs_pkg::MAX_REQUEST_BYTES) : i_byte_count;
    assign w_sum = SW'(i_start_address[SL-1:0]) + SW'(w_len) - SW'(1);

    // bytes left before the next page boundary
    assign w_room = PW'(fwcs_pkg::PAGE_BYTES) - {1'b0, r_cur[PL-1:0]};
    assign w_fits = r_rem <= CW'(w_room);
    assign w_size = w_fits ? PW'(r_rem) : w_room;

    always_comb begin
        o_stat.len_zero  = (i_byte_count == '0);
        o_stat.sect_last = (r_sect_left == '0);
        o_stat.prog_last = w_fits;
        o_stat.out_free  = !r_o_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_base      <= {i_start_address[AW-1:SL], {SL{1'b0}}};
            r_cur       <= i_start_address;
            r_rem       <= w_len;
            r_off       <= '0;
            r_sect_left <= w_sum[SW-1:SL];
        end else begin
            if (i_ctl.emit_erase) begin
                r_base      <= r_base + AW'(fwcs_pkg::SECTOR_BYTES);
                r_sect_left <= r_sect_left - NW'(1);
            end
            if (i_ctl.emit_prog) begin
                r_cur <= r_cur + AW'(w_size);
                r_rem <= r_rem - CW'(w_size);
                r_off <= r_off + CW'(w_size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_stat.out_free) begin
            r_o_valid <= i_ctl.emit_erase || i_ctl.emit_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_erase) begin
            r_kind   <= fwcs_pkg::KIND_ERASE;
            r_taddr  <= r_base;
            r_pbytes <= '0;
            r_soff   <= '0;
            r_last   <= 1'b0;
        end else if (i_ctl.emit_prog) begin
            r_kind   <= fwcs_pkg::KIND_PROGRAM;
            r_taddr  <= r_cur;
            r_pbytes <= w_size;
            r_soff   <= r_off[fwcs_pkg::OFFSET_W-1:0];
            r_last   <= w_fits;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_command_kind   = r_kind;
    assign o_target_address = r_taddr;
    assign o_program_bytes  = r_pbytes;
    assign o_source_offset  = r_soff;
    assign o_last_command   = r_last;

    `FWCS_ASSERT(a_erase_fields, i_clk, i_rst_n,
                 (r_o_valid && r_kind == fwcs_pkg::KIND_ERASE)
                 |-> (r_pbytes == '0 && r_soff == '0 && !r_last))
    `FWCS_ASSERT(a_prog_nonempty, i_clk, i_rst_n,
                 (r_o_valid && r_kind == fwcs_pkg::KIND_PROGRAM) |-> (r_pbytes != '0))
    `FWCS_ASSERT(a_last_drains, i_clk, i_rst_n,
                 (i_ctl.emit_prog && w_fits) |=> (r_rem == '0))

endmodule

`default_nettype wire
